// ===== rtl/sudt_pkg.sv =====
`default_nettype none

package sudt_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 8;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    // compare stage status from the table to the sequencer
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } scan_status_t;

endpackage

`default_nettype wire

// ===== rtl/sudt_table.sv =====
`default_nettype none

module sudt_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [sudt_pkg::IDX_W-1:0]   wr_addr,
    input  wire logic [sudt_pkg::VALUE_W-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [sudt_pkg::IDX_W-1:0]   rd_addr,
    input  wire logic [sudt_pkg::VALUE_W-1:0] key,
    output sudt_pkg::scan_status_t            status
);
    import sudt_pkg::*;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
        end
    end

    // single shared 32-bit comparator, one entry per cycle
    always_comb
    begin
        status.vld = rd_vld_reg;
        status.hit = rd_vld_reg && (rd_data_reg == key);
        status.idx = rd_idx_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/set_union_dedup_table.sv =====
// Channel  | Handshake           | Beat fields
// req      | req_valid/req_stall | action, value
// rsp      | rsp_valid/rsp_stall | added, position, count, full_res
//
// Append, clear and unused actions: rsp_valid in the cycle after accept.
// Insert-if-absent: one table read per cycle through a single comparator, from index 0
// up to a match or the last stored entry; a value without a match is then appended if room remains.
// req_stall is high from accept until the rsp beat is taken.
// Reset clears the entry count; table contents need no clearing.
`default_nettype none

module set_union_dedup_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [1:0]                   action,
    input  wire logic signed [sudt_pkg::VALUE_W-1:0] value,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic                              added,
    output logic [sudt_pkg::POS_W-1:0]        position,
    output logic [sudt_pkg::COUNT_W-1:0]      count,
    output logic                              full_res
);
    import sudt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               added_reg, added_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               full_reg, full_next;

    logic               accept;
    logic               rd_more;
    logic               do_append;
    logic               wr_en;
    logic [VALUE_W-1:0] wr_data;
    scan_status_t       scan;

    assign accept  = req_valid && (state_reg == ST_IDLE);
    assign rd_more = (rd_idx_reg < cnt_reg);

    sudt_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   ((state_reg == ST_SCAN) && rd_more),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .key     (value_reg),
        .status  (scan)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action_t'(action) == ACT_INSERT) ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (scan.hit || (!rd_more && !scan.vld))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        value_next  = value_reg;
        added_next  = added_reg;
        pos_next    = pos_reg;
        full_next   = full_reg;
        do_append   = 1'b0;
        wr_en       = 1'b0;
        wr_data     = (state_reg == ST_IDLE) ? value : value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next  = value;
                    rd_idx_next = '0;
                    added_next  = 1'b0;
                    pos_next    = '0;
                    full_next   = 1'b0;
                    case (action_t'(action))
                        ACT_APPEND: do_append = 1'b1;
                        ACT_CLEAR:  cnt_next  = '0;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_more)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (scan.hit)
                begin
                    pos_next = scan.idx;
                end
                else if (!rd_more && !scan.vld)
                begin
                    do_append = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_append)
        begin
            if (cnt_reg == CNT_W'(CAPACITY))
            begin
                added_next = 1'b0;
                pos_next   = '0;
                full_next  = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                added_next = 1'b1;
                pos_next   = cnt_reg[IDX_W-1:0];
                full_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        value_reg  <= value_next;
        added_reg  <= added_next;
        pos_reg    <= pos_next;
        full_reg   <= full_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);
    assign added     = added_reg;
    assign position  = POS_W'(pos_reg);
    assign count     = COUNT_W'(cnt_reg);
    assign full_res  = full_reg;

endmodule

`default_nettype wire

// ===== rtl/sudt_checker.sv =====
`default_nettype none

module sudt_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_stall,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_stall,
    input wire logic                         added,
    input wire logic [sudt_pkg::POS_W-1:0]   position,
    input wire logic [sudt_pkg::COUNT_W-1:0] count,
    input wire logic                         full_res
);
    import sudt_pkg::*;

    // a pending result keeps new requests out
    a_busy_on_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request side open while result pending");

    // refusal only when the table is at capacity
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && full_res) |-> (count == COUNT_W'(CAPACITY)) && !added)
        else $error("full_res without a full table");

    // a write always grows the count to one past its slot
    a_added_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && added) |-> (count == COUNT_W'(position) + 1'b1) && !full_res)
        else $error("added beat with inconsistent position/count");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid && $stable(position) && $stable(count))
        else $error("stalled result changed");

endmodule

bind set_union_dedup_table sudt_checker u_sudt_checker (.*);

`default_nettype wire
